>>> rtl/core/hw2d_pkg.sv
package hw2d_pkg;

    // Hamming constants in Q30
    localparam logic [31:0] HAM_A0  = 32'd579820585;
    localparam logic [31:0] HAM_A1  = 32'd493921239;
    localparam logic [32:0] Q30_ONE = 33'd1073741824;

    // configuration register indexes
    localparam logic [7:0] REG_NUM_ROWS = 8'd0;
    localparam logic [7:0] REG_NUM_COLS = 8'd1;

    localparam int CFG_W = 11;

    // quarter-cosine series coefficients, Q30
    function automatic logic [31:0] cos_coef(input logic [2:0] idx);
        logic [31:0] c;
        case (idx)
            3'd1:    c = 32'd1324675879;
            3'd2:    c = 32'd272375563;
            3'd3:    c = 32'd22401989;
            3'd4:    c = 32'd987046;
            3'd5:    c = 32'd27061;
            3'd6:    c = 32'd506;
            default: c = 32'd1073741824;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/hw2d_wgen.sv
// Serial Hamming weight generator: restoring divide for the phase, then a
// shared multiplier walks the cosine series, then the window scaling.
module hw2d_wgen #(
    parameter int KW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [KW-1:0] i_k,
    input  logic [KW:0]   i_n,
    output logic          o_done,
    output logic [15:0]   o_weight
);
    import hw2d_pkg::*;

    localparam int NW = KW + 16;
    localparam int CNTW = $clog2(NW);

    typedef enum logic [5:0] {
        G_IDLE = 6'b000001,
        G_DIV  = 6'b000010,
        G_SQR  = 6'b000100,
        G_MUL  = 6'b001000,
        G_SUB  = 6'b010000,
        G_AMUL = 6'b100000
    } t_gstate;

    t_gstate         r_state;
    logic            r_out;
    logic [NW-1:0]   r_num;
    logic [KW-1:0]   r_rem;
    logic [KW-1:0]   r_d;
    logic [CNTW-1:0] r_cnt;
    logic            r_one;
    logic            r_neg;
    logic [30:0]     r_v;
    logic [31:0]     r_acc;
    logic [62:0]     r_p;
    logic [2:0]      r_idx;
    logic [30:0]     r_mag;
    logic [15:0]     r_w;
    logic            r_done;

    // divider step
    logic [KW:0]   t_div;
    logic          ge;
    logic [KW:0]   diff;
    logic [KW-1:0] n_rem;
    assign t_div = {r_rem, r_num[NW-1]};
    assign ge    = t_div >= {1'b0, r_d};
    assign diff  = t_div - {1'b0, r_d};
    assign n_rem = ge ? diff[KW-1:0] : t_div[KW-1:0];

    // quadrant folding
    logic [15:0] ph;
    logic [14:0] g;
    logic [29:0] gg;
    assign ph = r_one ? 16'd0 : r_num[15:0];
    assign g  = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    assign gg = 30'(g) * 30'(g);

    // series tail and window
    logic [32:0] a_fin;
    logic [30:0] mag_fin;
    logic [32:0] m_w;
    logic [32:0] w_sum;
    logic [33:0] w_rnd;
    logic [19:0] w_q;
    assign a_fin   = r_p[62:30];
    assign mag_fin = (a_fin >= Q30_ONE) ? 31'd0 : 31'(Q30_ONE - a_fin);
    assign m_w     = r_p[62:30];
    always_comb begin
        if (r_neg) begin
            w_sum = {1'b0, HAM_A0} + m_w;
        end else begin
            w_sum = ({1'b0, HAM_A0} > m_w) ? ({1'b0, HAM_A0} - m_w) : 33'd0;
        end
        w_rnd = {1'b0, w_sum} + 34'd8192;
        w_q   = w_rnd[33:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_out   <= 1'b0;
            r_done  <= 1'b0;
        end else if (i_start) begin
            r_num   <= {i_k, 16'd0} + NW'((i_n - 1'b1) >> 1);
            r_d     <= KW'(i_n - 1'b1);
            r_one   <= (i_n <= 1);
            r_rem   <= '0;
            r_cnt   <= '0;
            r_out   <= 1'b0;
            r_done  <= 1'b0;
            r_state <= G_DIV;
        end else begin
            unique case (r_state)
                G_IDLE: begin
                    r_done <= 1'b0;
                end
                G_DIV: begin
                    r_done <= 1'b0;
                    r_rem  <= n_rem;
                    r_num  <= {r_num[NW-2:0], ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(NW - 1)) begin
                        r_state <= G_SQR;
                    end
                end
                G_SQR: begin
                    r_done  <= 1'b0;
                    r_v     <= {gg[28:0], 2'b00};
                    r_neg   <= ph[15] ^ ph[14];
                    r_acc   <= cos_coef(3'd6);
                    r_idx   <= 3'd5;
                    r_state <= G_MUL;
                end
                G_MUL: begin
                    r_p     <= 63'(r_v) * 63'(r_acc);
                    r_state <= r_out ? G_IDLE : G_SUB;
                    r_done  <= r_out;
                    if (r_out) begin
                        r_w <= (w_q > 20'd65535) ? 16'hFFFF : w_q[15:0];
                    end
                end
                G_SUB: begin
                    r_done <= 1'b0;
                    if (r_idx == 3'd0) begin
                        r_mag   <= mag_fin;
                        r_state <= G_AMUL;
                    end else begin
                        r_acc   <= cos_coef(r_idx) - r_p[61:30];
                        r_idx   <= r_idx - 1'b1;
                        r_state <= G_MUL;
                    end
                end
                G_AMUL: begin
                    // A1 * |cos|, output taken on the following cycle
                    r_done  <= 1'b0;
                    r_p     <= 63'(HAM_A1) * 63'(r_mag);
                    r_out   <= 1'b1;
                    r_state <= G_MUL;
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= G_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_weight = r_w;

endmodule

>>> rtl/core/hamming_window_2d_unit.sv
// An accepted item moves through r_smag1, r_p1, r_p2 and r_odata to the output.
// Throughput: one item per cycle with tables filled and the output not stalled.
// The tables are refilled after reset and after a write to the row or column
// count, one weight at a time by the serial divider and the shared series
// multiplier; input and config ready stay low meanwhile.
// Reset is synchronous, active low; position counters clear, tables refill.
module hamming_window_2d_unit #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [15:0]               i_s_axis_tdata,  // sample
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [15:0]               o_m_axis_tdata,  // windowed
    output logic                      o_m_axis_tlast,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [7:0]                i_cfg_index,
    input  logic [hw2d_pkg::CFG_W-1:0] i_cfg_data
);
    import hw2d_pkg::*;

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int KW = (RW > CW) ? RW : CW;

    typedef enum logic [2:0] {
        S_RUN = 3'b001,
        S_COL = 3'b010,
        S_ROW = 3'b100
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_num_rows;
    logic [CFG_W-1:0]   r_num_cols;
    logic [KW-1:0]      r_k;
    logic               r_kick;
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;

    logic [15:0] m_col [MAX_COLS];
    logic [15:0] m_row [MAX_ROWS];

    // effective sizes, clamped to [1, MAX]
    logic [12:0] ext_r, ext_c;
    logic [KW:0] eff_r, eff_c;
    assign ext_r = 13'(r_num_rows);
    assign ext_c = 13'(r_num_cols);
    assign eff_r = (ext_r == 13'd0) ? (KW+1)'(1) :
                   (32'(ext_r) > MAX_ROWS) ? (KW+1)'(MAX_ROWS) : (KW+1)'(ext_r);
    assign eff_c = (ext_c == 13'd0) ? (KW+1)'(1) :
                   (32'(ext_c) > MAX_COLS) ? (KW+1)'(MAX_COLS) : (KW+1)'(ext_c);

    // writes taken only between fills
    logic cfg_wr;
    assign o_cfg_ready = (r_state == S_RUN);
    assign cfg_wr = i_cfg_valid && o_cfg_ready &&
                    (i_cfg_index == REG_NUM_ROWS || i_cfg_index == REG_NUM_COLS);

    // weight generator
    logic        g_done;
    logic [15:0] g_w;
    hw2d_wgen #(.KW(KW)) u_wgen (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_kick),
        .i_k      (r_k),
        .i_n      ((r_state == S_ROW) ? eff_r : eff_c),
        .o_done   (g_done),
        .o_weight (g_w)
    );

    // pipeline control
    logic r_v1, r_v2, r_v3, r_ov;
    logic adv, acc;
    assign adv = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_RUN) && adv;
    assign acc = i_s_axis_tvalid && o_s_axis_tready;

    logic last_c, last_r;
    assign last_c = (r_col == CW'(eff_c - 1'b1));
    assign last_r = (r_row == RW'(eff_r - 1'b1));

    // fill sequencer, config registers, positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_COL;
            r_num_rows <= CFG_W'(256);
            r_num_cols <= CFG_W'(128);
            r_k        <= '0;
            r_kick     <= 1'b1;
            r_col      <= '0;
            r_row      <= '0;
        end else if (cfg_wr) begin
            if (i_cfg_index == REG_NUM_ROWS) begin
                r_num_rows <= i_cfg_data;
            end else begin
                r_num_cols <= i_cfg_data;
            end
            r_state <= S_COL;
            r_k     <= '0;
            r_kick  <= 1'b1;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                S_RUN: begin
                    r_kick <= 1'b0;
                    if (acc) begin
                        if (last_c) begin
                            r_col <= '0;
                            r_row <= last_r ? '0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                S_COL: begin
                    r_kick <= g_done;
                    if (g_done) begin
                        if ((KW+1)'(r_k) == eff_c - 1'b1) begin
                            r_k     <= '0;
                            r_state <= S_ROW;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_ROW: begin
                    r_kick <= g_done && ((KW+1)'(r_k) != eff_r - 1'b1);
                    if (g_done) begin
                        if ((KW+1)'(r_k) == eff_r - 1'b1) begin
                            r_state <= S_RUN;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_kick  <= 1'b0;
                    r_state <= S_RUN;
                end
            endcase
        end
    end

    // weight memories: fill writes, stream reads
    logic [15:0] r_wc, r_wr;
    always_ff @(posedge i_clk) begin
        if (r_state == S_COL && g_done) begin
            m_col[r_k[CW-1:0]] <= g_w;
        end
        if (adv) begin
            r_wc <= m_col[r_col];
        end
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_ROW && g_done) begin
            m_row[r_k[RW-1:0]] <= g_w;
        end
        if (adv) begin
            r_wr <= m_row[r_row];
        end
    end

    // datapath: magnitude x col weight, x row weight, round and saturate
    logic [16:0] smag;
    assign smag = i_s_axis_tdata[15] ? 17'(17'd65536 - {1'b0, i_s_axis_tdata})
                                     : {1'b0, i_s_axis_tdata};

    logic [16:0] r_smag1;
    logic        r_neg1, r_neg2, r_neg3, r_last1, r_last2, r_last3;
    logic [32:0] r_p1;
    logic [48:0] r_p2;
    logic [15:0] r_wr2;
    logic [15:0] r_odata;
    logic        r_olast;

    logic [49:0] p_rnd;
    logic [17:0] m_rnd;
    logic [15:0] res;
    assign p_rnd = {1'b0, r_p2} + 50'd2147483648;
    assign m_rnd = p_rnd[49:32];
    always_comb begin
        if (r_neg3) begin
            res = (m_rnd >= 18'd32768) ? 16'h8000 : 16'(~m_rnd[15:0] + 1'b1);
        end else begin
            res = (m_rnd >= 18'd32767) ? 16'h7FFF : m_rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_smag1 <= smag;
            r_neg1  <= i_s_axis_tdata[15];
            r_last1 <= last_c && last_r;
            r_p1    <= 33'(r_smag1) * 33'(r_wc);
            r_wr2   <= r_wr;
            r_neg2  <= r_neg1;
            r_last2 <= r_last1;
            r_p2    <= 49'(r_p1) * 49'(r_wr2);
            r_neg3  <= r_neg2;
            r_last3 <= r_last2;
            r_odata <= res;
            r_olast <= r_last3;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

endmodule

>>> rtl/core/hw2d_checker.sv
// Port-level checks for the window unit.
module hw2d_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [7:0]  i_cfg_index
);
    import hw2d_pkg::*;

    // no output right after a reset cycle
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // no input taken right after a reset cycle (tables refill)
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_s_axis_tready)
        else $error("input ready after reset");

    // a register write restarts the table fill
    a_cfg_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready &&
         (i_cfg_index == REG_NUM_ROWS || i_cfg_index == REG_NUM_COLS))
        |=> !o_s_axis_tready)
        else $error("input ready right after config write");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled item changed");

endmodule

bind hamming_window_2d_unit hw2d_props u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .i_cfg_valid     (i_cfg_valid),
    .o_cfg_ready     (o_cfg_ready),
    .i_cfg_index     (i_cfg_index)
);

>>> sim/hw2d_checker.sv
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels, predicts every
// windowed sample and its frame_end flag, and compares them in order.
module hw2d_checker #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    input  logic                        i_s_axis_tready,
    input  logic [15:0]                 i_s_axis_tdata,
    input  logic                        i_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    input  logic [15:0]                 i_m_axis_tdata,
    input  logic                        i_m_axis_tlast,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [7:0]                  i_cfg_index,
    input  logic [hw2d_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_frames
);
    import hw2d_pkg::*;

    typedef struct packed {
        logic [15:0] windowed;
        logic        frame_end;
    } window_result_t;

    // quarter-cosine series coefficients, Q30
    localparam longint unsigned SERIES [7] = '{
        64'd1073741824, 64'd1324675879, 64'd272375563, 64'd22401989,
        64'd987046, 64'd27061, 64'd506
    };

    logic [CFG_W-1:0] rows_reg, cols_reg;
    int unsigned      col_pos, row_pos;
    logic [15:0]      col_w [MAX_COLS];
    logic [15:0]      row_w [MAX_ROWS];
    bit               tables_valid;
    window_result_t   expected_results [$];

    function automatic int unsigned clamp_size(int unsigned v, int unsigned lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // cos(pi/2 * g/16384) in Q30
    function automatic longint unsigned quarter_cosine(int unsigned g);
        longint unsigned u, v, acc;
        u = longint'(g) << 16;
        v = (u * u) >> 30;
        acc = SERIES[6];
        for (int n = 5; n >= 1; n--) acc = SERIES[n] - ((v * acc) >> 30);
        acc = (v * acc) >> 30;
        return (acc >= 64'(Q30_ONE)) ? 64'd0 : 64'(Q30_ONE) - acc;
    endfunction

    function automatic logic [15:0] hamming_coef(int unsigned k, int unsigned n);
        longint unsigned d, ph, mag, w;
        int unsigned     q, f;
        bit              neg;
        ph = 0;
        if (n > 1) begin
            d  = n - 1;
            ph = (((longint'(k) << 16) + d / 2) / d) & 64'hFFFF;
        end
        q = ph >> 14;
        f = ph & 64'h3FFF;
        case (q)
            0: begin mag = quarter_cosine(f);         neg = 0; end
            1: begin mag = quarter_cosine(16384 - f); neg = 1; end
            2: begin mag = quarter_cosine(f);         neg = 1; end
            default: begin mag = quarter_cosine(16384 - f); neg = 0; end
        endcase
        mag = (64'(HAM_A1) * mag) >> 30;
        if (neg) w = 64'(HAM_A0) + mag;
        else w = (64'(HAM_A0) > mag) ? 64'(HAM_A0) - mag : 64'd0;
        w = (w + 8192) >> 14;
        return (w > 65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic void build_tables();
        int unsigned nr, nc;
        nr = clamp_size(rows_reg, MAX_ROWS);
        nc = clamp_size(cols_reg, MAX_COLS);
        for (int unsigned k = 0; k < nc; k++) col_w[k] = hamming_coef(k, nc);
        for (int unsigned k = 0; k < nr; k++) row_w[k] = hamming_coef(k, nr);
        tables_valid = 1;
    endfunction

    function automatic window_result_t window_sample(logic [15:0] s);
        int unsigned     nr, nc;
        longint unsigned mag;
        longint          res;
        bit              neg;
        window_result_t  r;
        if (!tables_valid) build_tables();
        nr = clamp_size(rows_reg, MAX_ROWS);
        nc = clamp_size(cols_reg, MAX_COLS);
        if (col_pos >= nc) col_pos = 0;
        if (row_pos >= nr) row_pos = 0;
        neg = s[15];
        mag = neg ? (65536 - s) : s;
        mag = mag * col_w[col_pos] * row_w[row_pos];
        mag = (mag + 64'd2147483648) >> 32;
        res = neg ? -longint'(mag) : longint'(mag);
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        r.windowed  = res[15:0];
        r.frame_end = (col_pos == nc - 1) && (row_pos == nr - 1);
        col_pos++;
        if (col_pos >= nc) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= nr) row_pos = 0;
        end
        return r;
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        window_result_t exp_r;
        if (!i_rst_n) begin
            rows_reg = 11'd256;
            cols_reg = 11'd128;
            col_pos = 0;
            row_pos = 0;
            tables_valid = 0;
            expected_results.delete();
            o_fail_count <= 0;
            o_results <= 0;
            o_frames <= 0;
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_NUM_ROWS || i_cfg_index == REG_NUM_COLS) begin
                    if (i_cfg_index == REG_NUM_ROWS) rows_reg = i_cfg_data;
                    else cols_reg = i_cfg_data;
                    tables_valid = 0;
                    col_pos = 0;
                    row_pos = 0;
                end
            end
            // accepted sample
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_results.push_back(window_sample(i_s_axis_tdata));
            // accepted result
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                o_results <= o_results + 1;
                if (i_m_axis_tlast) o_frames <= o_frames + 1;
                if (expected_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result %h/%b with nothing expected",
                                 $time, i_m_axis_tdata, i_m_axis_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.windowed !== i_m_axis_tdata
                            || exp_r.frame_end !== i_m_axis_tlast) begin
                        if (o_fail_count < 10)
                            $display("%0t: windowed exp %h got %h, frame_end exp %b got %b",
                                     $time, exp_r.windowed, i_m_axis_tdata,
                                     exp_r.frame_end, i_m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import hw2d_pkg::*;

    localparam logic [7:0] REG_SPARE = 8'd2;  // not a register, write is ignored
    localparam int STALL_LIMIT = 250000;
    localparam int TAIL_CYCLES = 12;

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [15:0]         s_tdata = 0;
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [15:0]         m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 0;
    logic                cfg_ready;
    logic [7:0]          cfg_index = 0;
    logic [CFG_W-1:0]    cfg_data = 0;
    int                  fail_count, pending, results, frames;
    int                  cfg_writes = 0;
    int                  stall_cycles = 0;
    bit                  steady = 0;  // no idling on either side while set

    logic [15:0] directed [] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
                                 16'h5555, 16'hAAAA, 16'h4000, 16'hC000, 16'h00FF,
                                 16'hFF00, 16'h8001, 16'h7FFE, 16'h0F0F, 16'hF0F0};

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    hamming_window_2d_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    hw2d_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_frames(frames)
    );

    // result side backpressure
    always @(negedge i_clk) begin
        m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 10);
    end

    // watchdog: cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input logic [15:0] value);
        if (!steady && $urandom_range(99) < 4) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // let every result come back, then the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frames(input int unsigned count);
        repeat (count) send_sample(rand_sample());
    endtask

    initial begin
        int unsigned nr, nc, sent, cnt;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset sizes: sample extremes and bit patterns
        foreach (directed[i]) send_sample(directed[i]);
        drain();

        // single-point frame, every sample is the last one
        write_reg(REG_NUM_ROWS, 1);
        write_reg(REG_NUM_COLS, 1);
        repeat (6) send_sample(rand_sample());
        drain();
        // zero sizes clamp to one
        write_reg(REG_NUM_ROWS, 0);
        write_reg(REG_NUM_COLS, 0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain();
        // oversized rows clamp to the maximum, largest column count
        write_reg(REG_NUM_ROWS, 2047);
        send_frames(30);
        drain();
        write_reg(REG_NUM_ROWS, 1);
        write_reg(REG_NUM_COLS, 1024);
        send_frames(30);
        drain();

        // random small maps, mostly whole frames
        sent = 0;
        while (sent < 900) begin
            steady = ($urandom_range(9) == 0);
            nr = $urandom_range(1, 12);
            nc = $urandom_range(1, 12);
            if ($urandom_range(1)) begin
                write_reg(REG_NUM_ROWS, nr);
                write_reg(REG_NUM_COLS, nc);
            end else begin
                write_reg(REG_NUM_COLS, nc);
                write_reg(REG_NUM_ROWS, nr);
            end
            cnt = nr * nc * $urandom_range(1, 2) + $urandom_range(0, 3);
            send_frames(cnt);
            sent += cnt;
            drain();
            // a spare index or a rewrite of the same size mid-frame
            if ($urandom_range(3) == 0) begin
                write_reg(REG_SPARE, $urandom);
                send_frames(nr * nc);
                sent += nr * nc;
                drain();
            end else if ($urandom_range(3) == 0) begin
                write_reg(REG_NUM_COLS, nc);
                send_frames(nc + 2);
                sent += nc + 2;
                drain();
            end
        end
        steady = 0;

        $display("results checked: %0d, frames closed: %0d, register writes: %0d",
                 results, frames, cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("mismatches: %0d, results missing: %0d", fail_count, pending);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hw2d_pkg.sv
rtl/core/hw2d_wgen.sv
rtl/core/hamming_window_2d_unit.sv
rtl/core/hw2d_checker.sv
sim/hw2d_checker.sv
sim/tb.sv
